[rtl/obstacle_avoid_steering_unit_macros.svh]
// Assertion macros for the obstacle avoid steering unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef OBSTACLE_AVOID_STEERING_UNIT_MACROS_SVH
`define OBSTACLE_AVOID_STEERING_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define OSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("obstacle avoid steering: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define OSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("obstacle avoid steering: next-cycle check failed");

`endif

[rtl/osa_pkg.sv]
// Shared types and constants of the obstacle avoid steering unit.
// No dependencies; used by the interfaces, the datapath and the top level.
`default_nettype none

package osa_pkg;

  // Default sizing of the top-level parameters
  localparam int unsigned SAMPLE_BITS_DEF = 10;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  // Fixed field widths
  localparam int unsigned HOLD_LIMIT_BITS = 16;
  localparam int unsigned RUN_LENGTH_BITS = 16;
  localparam int unsigned CFG_IDX_BITS    = 3;
  localparam int unsigned DIR_BITS        = 3;
  localparam int unsigned PAT_BITS        = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRONT_THR  = 3'd0,
    CFG_LEFT_THR   = 3'd1,
    CFG_RIGHT_THR  = 3'd2,
    CFG_LDRIFT_THR = 3'd3,
    CFG_RDRIFT_THR = 3'd4,
    CFG_HOLD_LIMIT = 3'd5
  } cfg_idx_e;

  // Steering direction codes
  typedef enum logic [DIR_BITS-1:0] {
    DIR_STOP   = 3'd0,
    DIR_FWD    = 3'd1,
    DIR_FLEFT  = 3'd2,
    DIR_FRIGHT = 3'd3,
    DIR_RLEFT  = 3'd4,
    DIR_RRIGHT = 3'd5,
    DIR_REV    = 3'd6
  } dir_e;

  // Obstacle patterns: left in bit 2, front in bit 1, right in bit 0
  localparam logic [PAT_BITS-1:0] PAT_NONE       = 3'b000;
  localparam logic [PAT_BITS-1:0] PAT_RIGHT      = 3'b001;
  localparam logic [PAT_BITS-1:0] PAT_FRONT      = 3'b010;
  localparam logic [PAT_BITS-1:0] PAT_FRONT_RGT  = 3'b011;
  localparam logic [PAT_BITS-1:0] PAT_LEFT       = 3'b100;
  localparam logic [PAT_BITS-1:0] PAT_LEFT_RIGHT = 3'b101;
  localparam logic [PAT_BITS-1:0] PAT_LEFT_FRONT = 3'b110;
  localparam logic [PAT_BITS-1:0] PAT_ALL        = 3'b111;

  // Held steering decision
  typedef struct packed {
    logic [PAT_BITS-1:0] pattern;
    dir_e                direction;
  } held_t;

endpackage

`default_nettype wire

[rtl/osa_in_if.sv]
// Input channel of the obstacle avoid steering unit: sample set plus recheck set.
// Depends on osa_pkg for the default width; width follows the SAMPLE_BITS parameter.
`default_nettype none

interface osa_in_if #(
  parameter int unsigned SAMPLE_BITS = osa_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] front_sample;
  logic [SAMPLE_BITS-1:0] right_sample;
  logic [SAMPLE_BITS-1:0] left_sample;
  logic [SAMPLE_BITS-1:0] front_recheck;
  logic [SAMPLE_BITS-1:0] right_recheck;
  logic [SAMPLE_BITS-1:0] left_recheck;

  modport source (
    output valid, front_sample, right_sample, left_sample,
    output front_recheck, right_recheck, left_recheck,
    input  ready
  );

  modport sink (
    input  valid, front_sample, right_sample, left_sample,
    input  front_recheck, right_recheck, left_recheck,
    output ready
  );
endinterface

`default_nettype wire

[rtl/osa_out_if.sv]
// Result channel of the obstacle avoid steering unit.
// Depends on osa_pkg for the field widths.
`default_nettype none

interface osa_out_if;
  logic                                valid;
  logic                                ready;
  logic [osa_pkg::DIR_BITS-1:0]        steer_direction;
  logic                                hard_stop_request;
  logic [osa_pkg::RUN_LENGTH_BITS-1:0] run_length;

  modport source (
    output valid, steer_direction, hard_stop_request, run_length,
    input  ready
  );

  modport sink (
    input  valid, steer_direction, hard_stop_request, run_length,
    output ready
  );
endinterface

`default_nettype wire

[rtl/obstacle_avoid_steering_unit.sv]
// An accepted input transaction is captured in the input register and passes through the
// decision logic into the result register, which holds the result until it is taken.
// Throughput: one item per cycle while the result side is not stalled; the held direction,
// hold and run counters close their feedback loop through the decision logic alone.
// Reset (async, active low) clears configuration, held state, counters and valid flags.
`default_nettype none
`include "obstacle_avoid_steering_unit_macros.svh"

module obstacle_avoid_steering_unit #(
  parameter int unsigned SAMPLE_BITS = osa_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = osa_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [osa_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [((SAMPLE_BITS > osa_pkg::HOLD_LIMIT_BITS) ?
                 SAMPLE_BITS : osa_pkg::HOLD_LIMIT_BITS)-1:0] cfg_wdata_i,
  osa_in_if.sink                               in_i,
  osa_out_if.source                            out_o
);

  localparam int unsigned CFG_DATA_BITS = (SAMPLE_BITS > osa_pkg::HOLD_LIMIT_BITS) ?
                                          SAMPLE_BITS : osa_pkg::HOLD_LIMIT_BITS;

  logic [SAMPLE_BITS-1:0]              front_thr, left_thr, right_thr;
  logic [SAMPLE_BITS-1:0]              ldrift_thr, rdrift_thr;
  logic [osa_pkg::HOLD_LIMIT_BITS-1:0] hold_limit;

  osa_cfg_regs #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DATA_BITS   (CFG_DATA_BITS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .front_thr_o  (front_thr),
    .left_thr_o   (left_thr),
    .right_thr_o  (right_thr),
    .ldrift_thr_o (ldrift_thr),
    .rdrift_thr_o (rdrift_thr),
    .hold_limit_o (hold_limit)
  );

  // Input stage
  logic                   in_vld_q, in_vld_d;
  logic [SAMPLE_BITS-1:0] fs_q, rs_q, ls_q, fr_q, rr_q, lr_q;
  logic                   in_take, fire;

  // Result stage and held state
  logic                                out_vld_q, out_vld_d;
  logic [osa_pkg::DIR_BITS-1:0]        dir_q, dir_d;
  logic                                hs_q, hs_d;
  logic [osa_pkg::RUN_LENGTH_BITS-1:0] run_len_q, run_len_d;
  osa_pkg::held_t                      held_q, held_d;
  logic [COUNT_BITS-1:0]               hold_count_q, hold_count_d;
  logic [COUNT_BITS-1:0]               run_count_q, run_count_d;

  // Advance the input stage when the result register is free or drained
  assign fire       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || fire;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take)   in_vld_d = 1'b1;
    else if (fire) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Capture the sample payload of an accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      fs_q <= in_i.front_sample;
      rs_q <= in_i.right_sample;
      ls_q <= in_i.left_sample;
      fr_q <= in_i.front_recheck;
      rr_q <= in_i.right_recheck;
      lr_q <= in_i.left_recheck;
    end
  end

  osa_step #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_step (
    .front_sample_i    (fs_q),
    .right_sample_i    (rs_q),
    .left_sample_i     (ls_q),
    .front_recheck_i   (fr_q),
    .right_recheck_i   (rr_q),
    .left_recheck_i    (lr_q),
    .front_thr_i       (front_thr),
    .left_thr_i        (left_thr),
    .right_thr_i       (right_thr),
    .ldrift_thr_i      (ldrift_thr),
    .rdrift_thr_i      (rdrift_thr),
    .hold_limit_i      (hold_limit),
    .held_i            (held_q),
    .hold_count_i      (hold_count_q),
    .run_count_i       (run_count_q),
    .held_o            (held_d),
    .hold_count_o      (hold_count_d),
    .run_count_o       (run_count_d),
    .steer_direction_o (dir_d),
    .halt_req_o        (hs_d),
    .run_length_o      (run_len_d)
  );

  // Hold a result until taken; update state once per processed item
  always_comb begin
    out_vld_d = out_vld_q;
    if (fire)             out_vld_d = 1'b1;
    else if (out_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q    <= 1'b0;
      held_q       <= '{pattern: osa_pkg::PAT_NONE, direction: osa_pkg::DIR_STOP};
      hold_count_q <= '0;
      run_count_q  <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      if (fire) begin
        held_q       <= held_d;
        hold_count_q <= hold_count_d;
        run_count_q  <= run_count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      dir_q     <= dir_d;
      hs_q      <= hs_d;
      run_len_q <= run_len_d;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.steer_direction   = dir_q;
  assign out_o.hard_stop_request = hs_q;
  assign out_o.run_length        = run_len_q;

  // Run length is only reported alongside a hard stop
  `OSA_ASSERT_IMP(a_len_needs_stop, clk_i, rst_ni, out_vld_q && !hs_q, run_len_q == '0)
  // Directions stay within the defined codes
  `OSA_ASSERT_IMP(a_dir_legal, clk_i, rst_ni, out_vld_q, dir_q <= osa_pkg::DIR_REV)
  // Held decision moves only when an item is processed
  `OSA_ASSERT_NXT(a_held_quiet, clk_i, rst_ni, !fire, $stable(held_q))
  // A change of held direction restarts the hold count
  `OSA_ASSERT_NXT(a_change_clears_hold, clk_i, rst_ni, fire && (held_d.direction != held_q.direction), hold_count_q == '0)

endmodule

`default_nettype wire

[rtl/osa_cfg_regs.sv]
// Configuration register file: thresholds and hold limit.
// Depends on osa_pkg for register indexes and widths.
`default_nettype none

module osa_cfg_regs #(
  parameter int unsigned SAMPLE_BITS = osa_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned DATA_BITS   = osa_pkg::HOLD_LIMIT_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [osa_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [DATA_BITS-1:0]                cfg_wdata_i,
  output logic [SAMPLE_BITS-1:0]              front_thr_o,
  output logic [SAMPLE_BITS-1:0]              left_thr_o,
  output logic [SAMPLE_BITS-1:0]              right_thr_o,
  output logic [SAMPLE_BITS-1:0]              ldrift_thr_o,
  output logic [SAMPLE_BITS-1:0]              rdrift_thr_o,
  output logic [osa_pkg::HOLD_LIMIT_BITS-1:0] hold_limit_o
);

  logic [SAMPLE_BITS-1:0]              front_thr_q, left_thr_q, right_thr_q;
  logic [SAMPLE_BITS-1:0]              ldrift_thr_q, rdrift_thr_q;
  logic [osa_pkg::HOLD_LIMIT_BITS-1:0] hold_limit_q;

  // Write the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_thr_q  <= '0;
      left_thr_q   <= '0;
      right_thr_q  <= '0;
      ldrift_thr_q <= '0;
      rdrift_thr_q <= '0;
      hold_limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        osa_pkg::CFG_FRONT_THR:  front_thr_q  <= cfg_wdata_i[SAMPLE_BITS-1:0];
        osa_pkg::CFG_LEFT_THR:   left_thr_q   <= cfg_wdata_i[SAMPLE_BITS-1:0];
        osa_pkg::CFG_RIGHT_THR:  right_thr_q  <= cfg_wdata_i[SAMPLE_BITS-1:0];
        osa_pkg::CFG_LDRIFT_THR: ldrift_thr_q <= cfg_wdata_i[SAMPLE_BITS-1:0];
        osa_pkg::CFG_RDRIFT_THR: rdrift_thr_q <= cfg_wdata_i[SAMPLE_BITS-1:0];
        osa_pkg::CFG_HOLD_LIMIT: begin
          hold_limit_q <= cfg_wdata_i[osa_pkg::HOLD_LIMIT_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  assign front_thr_o  = front_thr_q;
  assign left_thr_o   = left_thr_q;
  assign right_thr_o  = right_thr_q;
  assign ldrift_thr_o = ldrift_thr_q;
  assign rdrift_thr_o = rdrift_thr_q;
  assign hold_limit_o = hold_limit_q;

endmodule

`default_nettype wire

[rtl/osa_step.sv]
// Steering decision datapath: pattern, direction map, escape, drift and hold rules.
// Purely combinational; depends on osa_pkg for codes and the held-state type.
`default_nettype none

module osa_step #(
  parameter int unsigned SAMPLE_BITS = osa_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = osa_pkg::COUNT_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0]              front_sample_i,
  input  logic [SAMPLE_BITS-1:0]              right_sample_i,
  input  logic [SAMPLE_BITS-1:0]              left_sample_i,
  input  logic [SAMPLE_BITS-1:0]              front_recheck_i,
  input  logic [SAMPLE_BITS-1:0]              right_recheck_i,
  input  logic [SAMPLE_BITS-1:0]              left_recheck_i,
  input  logic [SAMPLE_BITS-1:0]              front_thr_i,
  input  logic [SAMPLE_BITS-1:0]              left_thr_i,
  input  logic [SAMPLE_BITS-1:0]              right_thr_i,
  input  logic [SAMPLE_BITS-1:0]              ldrift_thr_i,
  input  logic [SAMPLE_BITS-1:0]              rdrift_thr_i,
  input  logic [osa_pkg::HOLD_LIMIT_BITS-1:0] hold_limit_i,
  input  osa_pkg::held_t                      held_i,
  input  logic [COUNT_BITS-1:0]               hold_count_i,
  input  logic [COUNT_BITS-1:0]               run_count_i,
  output osa_pkg::held_t                      held_o,
  output logic [COUNT_BITS-1:0]               hold_count_o,
  output logic [COUNT_BITS-1:0]               run_count_o,
  output logic [osa_pkg::DIR_BITS-1:0]        steer_direction_o,
  output logic                                halt_req_o,
  output logic [osa_pkg::RUN_LENGTH_BITS-1:0] run_length_o
);

  localparam int unsigned CMP_BITS = (COUNT_BITS > osa_pkg::HOLD_LIMIT_BITS) ?
                                     COUNT_BITS : osa_pkg::HOLD_LIMIT_BITS;
  localparam logic [CMP_BITS-1:0] CMAX_EXT = CMP_BITS'({COUNT_BITS{1'b1}});

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [osa_pkg::PAT_BITS-1:0] make_pattern(
    input logic [SAMPLE_BITS-1:0] f,
    input logic [SAMPLE_BITS-1:0] r,
    input logic [SAMPLE_BITS-1:0] l
  );
    return {l > left_thr_i, f > front_thr_i, r > right_thr_i};
  endfunction

  // Map an obstacle pattern to a direction
  function automatic osa_pkg::dir_e decide(
    input logic [osa_pkg::PAT_BITS-1:0] p,
    input logic [SAMPLE_BITS-1:0]       r,
    input logic [SAMPLE_BITS-1:0]       l
  );
    osa_pkg::dir_e d;
    unique case (p)
      osa_pkg::PAT_NONE:       d = osa_pkg::DIR_FWD;
      osa_pkg::PAT_RIGHT:      d = osa_pkg::DIR_FLEFT;
      osa_pkg::PAT_FRONT:      d = (r > l) ? osa_pkg::DIR_RRIGHT : osa_pkg::DIR_RLEFT;
      osa_pkg::PAT_FRONT_RGT:  d = osa_pkg::DIR_RRIGHT;
      osa_pkg::PAT_LEFT:       d = osa_pkg::DIR_FRIGHT;
      osa_pkg::PAT_LEFT_RIGHT: d = osa_pkg::DIR_FWD;
      osa_pkg::PAT_LEFT_FRONT: d = osa_pkg::DIR_RLEFT;
      default:                 d = osa_pkg::DIR_REV;
    endcase
    return d;
  endfunction

  logic [SAMPLE_BITS-1:0]       fv, rv, lv;
  logic [osa_pkg::PAT_BITS-1:0] ps, ns, tp;
  osa_pkg::dir_e                pd, nd, td;
  logic                         hs, fwd;
  logic [COUNT_BITS-1:0]        run, hold, runlen, lim_inc;
  logic [CMP_BITS-1:0]          lim_ext;
  osa_pkg::held_t               held_nx;

  // Evaluate the rules in order for one sample set
  always_comb begin
    fv      = front_sample_i;
    rv      = right_sample_i;
    lv      = left_sample_i;
    ps      = held_i.pattern;
    pd      = held_i.direction;
    ns      = make_pattern(fv, rv, lv);
    nd      = decide(ns, rv, lv);
    tp      = osa_pkg::PAT_NONE;
    td      = osa_pkg::DIR_STOP;
    hs      = 1'b0;
    fwd     = 1'b0;
    runlen  = '0;
    run     = run_count_i;
    hold    = hold_count_i;
    held_nx = held_i;
    lim_ext = CMP_BITS'(hold_limit_i);
    lim_inc = (lim_ext >= CMAX_EXT) ? {COUNT_BITS{1'b1}} : COUNT_BITS'(lim_ext + 1'b1);

    // Same direction, box pass-through, or escape from forward into reverse
    if (nd == pd) begin
      run  = sat_inc(run);
      hold = sat_inc(hold);
    end else if (ps == osa_pkg::PAT_ALL && ns == osa_pkg::PAT_LEFT_RIGHT) begin
      run = sat_inc(run);
      nd  = pd;
      ns  = ps;
    end else if ((pd == osa_pkg::DIR_FWD || pd == osa_pkg::DIR_FRIGHT ||
                  pd == osa_pkg::DIR_FLEFT) && nd == osa_pkg::DIR_REV) begin
      if (ps == osa_pkg::PAT_ALL) begin
        hs     = 1'b1;
        runlen = run;
      end
      fv = front_recheck_i;
      rv = right_recheck_i;
      lv = left_recheck_i;
      tp = make_pattern(fv, rv, lv);
      td = decide(tp, rv, lv);
      if (td == osa_pkg::DIR_FWD) begin
        nd = td;
        ns = tp;
      end
      run = '0;
    end

    // Keep a one-sided turn until the side clears into the corridor pattern
    if ((ps == osa_pkg::PAT_LEFT || ps == osa_pkg::PAT_RIGHT) &&
        ns != osa_pkg::PAT_LEFT_RIGHT) begin
      ns  = ps;
      nd  = pd;
      run = sat_inc(run);
    end

    // Straightness correction on the drift thresholds
    if (nd == osa_pkg::DIR_FWD || nd == osa_pkg::DIR_REV) begin
      fwd = (nd == osa_pkg::DIR_FWD);
      if (lv > ldrift_thr_i) begin
        if (fwd) nd = osa_pkg::DIR_FRIGHT;
        else     nd = osa_pkg::DIR_RRIGHT;
      end else if (rv > rdrift_thr_i) begin
        if (fwd) nd = osa_pkg::DIR_FLEFT;
        else     nd = osa_pkg::DIR_RLEFT;
      end
      hold = lim_inc;
    end
    run = sat_inc(run);

    // Gate the change of direction with the hold count
    if (nd == pd) begin
      hold = sat_inc(hold);
    end else if (CMP_BITS'(hold) > lim_ext) begin
      hold              = '0;
      held_nx.direction = nd;
      held_nx.pattern   = ns;
    end else begin
      nd   = pd;
      hold = sat_inc(hold);
    end
  end

  assign held_o            = held_nx;
  assign hold_count_o      = hold;
  assign run_count_o       = run;
  assign steer_direction_o = nd;
  assign halt_req_o        = hs;
  assign run_length_o      = osa_pkg::RUN_LENGTH_BITS'(runlen);

endmodule

`default_nettype wire
